// ===== design/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg: shared types and constants for the fuzzy PD controller
// Widths, register indexes, reset values and membership scaling.
// ----------------------------------------------------------------------------
package fpd_pkg;

    localparam int InWidth   = 16;
    localparam int SpanWidth = 15;
    localparam int StepWidth = 13;
    localparam int FracBits  = 12;
    localparam int MuWidth   = FracBits + 1;           // 0..H
    localparam int MagWidth  = InWidth;                // |x| up to 2^15
    localparam int NumWidth  = MagWidth + FracBits;    // |x| << F
    localparam int AreaWidth = 2 * FracBits + 4;       // 4hH fits
    localparam int TotWidth  = AreaWidth + 3;          // sum of five areas
    localparam int DiffWidth = AreaWidth + 3;          // 2a+b difference
    localparam int ProdWidth = DiffWidth + StepWidth;  // weighted magnitude
    localparam int QuoWidth  = 17;                     // up to 32768 after clamp
    localparam int DivNumWidth = ProdWidth + 2;        // 2*mag + total
    localparam int DivDenWidth = TotWidth + 1;         // 2*total

    localparam logic [MuWidth-1:0] MuFull = MuWidth'(1) << FracBits;

    localparam logic [1:0] RegPosSpan = 2'd0;
    localparam logic [1:0] RegVelSpan = 2'd1;
    localparam logic [1:0] RegOutStep = 2'd2;

    localparam logic [SpanWidth-1:0] PosSpanReset = 15'd1280;
    localparam logic [SpanWidth-1:0] VelSpanReset = 15'd640;
    localparam logic [StepWidth-1:0] OutStepReset = 13'd7680;

    typedef struct packed {
        logic [MuWidth-1:0] neg;
        logic [MuWidth-1:0] mid;
        logic [MuWidth-1:0] pos;
    } t_mu3;

    function automatic logic [MuWidth-1:0] mu_min(input logic [MuWidth-1:0] a,
                                                  input logic [MuWidth-1:0] b);
        mu_min = (a < b) ? a : b;
    endfunction

    function automatic logic [MuWidth-1:0] mu_max(input logic [MuWidth-1:0] a,
                                                  input logic [MuWidth-1:0] b);
        mu_max = (a > b) ? a : b;
    endfunction

endpackage

// ===== design/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div: pipelined restoring divider for the span division
// One quotient bit per stage; a new word may enter every cycle. The sign
// bits travel alongside so that the caller keeps its context.
// ----------------------------------------------------------------------------
module fpd_div
    import fpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [NumWidth-1:0]  i_num,
    input  logic [SpanWidth-1:0] i_den,
    input  logic [1:0]           i_side,
    output logic                 o_valid,
    output logic [NumWidth-1:0]  o_quo,
    output logic [1:0]           o_side
);

    logic [NumWidth:0]    r_vld;
    logic [SpanWidth:0]   r_rem  [NumWidth];
    logic [NumWidth-1:0]  r_quo  [NumWidth+1];
    logic [NumWidth-1:0]  r_num  [NumWidth];
    logic [SpanWidth-1:0] r_den  [NumWidth];
    logic [1:0]           r_side [NumWidth+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[NumWidth-1:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_quo[0]  <= '0;
        r_num[0]  <= i_num;
        r_den[0]  <= i_den;
        r_side[0] <= i_side;
    end

    for (genvar k = 0; k < NumWidth; k++) begin : g_stage
        logic [SpanWidth+1:0] w_trial;
        logic [SpanWidth+1:0] w_sub;
        assign w_trial = {r_rem[k], r_num[k][NumWidth-1-k]};
        assign w_sub   = w_trial - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            r_side[k+1] <= r_side[k];
            r_quo[k+1]  <= {r_quo[k][NumWidth-2:0], !w_sub[SpanWidth+1]};
        end
        if (k < NumWidth - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_num[k+1] <= r_num[k];
                r_den[k+1] <= r_den[k];
                r_rem[k+1] <= w_sub[SpanWidth+1] ? w_trial[SpanWidth:0] : w_sub[SpanWidth:0];
            end
        end
    end

    assign o_valid = r_vld[NumWidth];
    assign o_quo   = r_quo[NumWidth];
    assign o_side  = r_side[NumWidth];

endmodule

// ===== design/fpd_fuzz.sv =====
// ----------------------------------------------------------------------------
// fpd_fuzz: fuzzification of one input
// Magnitude, pipelined division by the span, clamp to full, split into
// negative / centre / positive memberships.
// ----------------------------------------------------------------------------
module fpd_fuzz
    import fpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [InWidth-1:0]   i_x,
    input  logic [SpanWidth-1:0] i_span,
    output logic                 o_valid,
    output t_mu3                 o_mu
);

    logic [MagWidth-1:0]  w_mag;
    logic [SpanWidth-1:0] w_span;
    logic [1:0]           w_sign;   // {neg, pos}
    logic                 w_qv;
    logic [NumWidth-1:0]  w_q;
    logic [1:0]           w_sign_q;
    logic [MuWidth-1:0]   w_qc;

    assign w_mag  = i_x[InWidth-1] ? MagWidth'(-i_x) : MagWidth'(i_x);
    assign w_span = (i_span == '0) ? SpanWidth'(1) : i_span;
    assign w_sign = {i_x[InWidth-1], (i_x != '0) && !i_x[InWidth-1]};

    fpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_num   ({w_mag, {FracBits{1'b0}}}),
        .i_den   (w_span),
        .i_side  (w_sign),
        .o_valid (w_qv),
        .o_quo   (w_q),
        .o_side  (w_sign_q)
    );

    assign w_qc = (w_q > NumWidth'(MuFull)) ? MuFull : w_q[MuWidth-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= w_qv;
        o_mu.neg <= w_sign_q[1] ? w_qc : '0;
        o_mu.pos <= w_sign_q[0] ? w_qc : '0;
        o_mu.mid <= MuFull - w_qc;
    end

endmodule

// ===== design/fpd_defuzz.sv =====
// ----------------------------------------------------------------------------
// fpd_defuzz: rule evaluation and center-of-sums defuzzification
// Rules and areas, signed moment, step multiply, pipelined divide by the
// total area, then rounding sign and saturation.
// ----------------------------------------------------------------------------
module fpd_defuzz
    import fpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_mu3                 i_p,
    input  t_mu3                 i_v,
    input  logic [StepWidth-1:0] i_step,
    output logic                 o_valid,
    output logic [15:0]          o_result
);

    // stage 1: rules
    logic                 r1_v;
    logic [MuWidth-1:0]   r1_nl, r1_ns, r1_z, r1_ps, r1_pl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= i_valid;
        r1_pl <= mu_min(i_p.neg, i_v.neg);
        r1_ps <= mu_max(mu_min(i_p.neg, i_v.mid), mu_min(i_p.mid, i_v.neg));
        r1_z  <= mu_max(mu_max(mu_min(i_p.neg, i_v.pos), mu_min(i_p.mid, i_v.mid)),
                        mu_min(i_p.pos, i_v.neg));
        r1_ns <= mu_max(mu_min(i_p.mid, i_v.pos), mu_min(i_p.pos, i_v.mid));
        r1_nl <= mu_min(i_p.pos, i_v.pos);
    end

    // stage 2: areas (one squaring per set)
    function automatic logic [AreaWidth-1:0] area(input logic [MuWidth-1:0] h,
                                                   input logic shoulder);
        logic [AreaWidth-1:0] lin;
        logic [AreaWidth-1:0] sq;
        lin = AreaWidth'(h) << (FracBits + 2);
        sq  = AreaWidth'(h) * AreaWidth'(h);
        area = shoulder ? lin - sq : lin - (sq << 1);
    endfunction

    logic                 r2_v;
    logic [AreaWidth-1:0] r2_nl, r2_ns, r2_z, r2_ps, r2_pl;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_nl <= area(r1_nl, 1'b1);
        r2_ns <= area(r1_ns, 1'b0);
        r2_z  <= area(r1_z,  1'b0);
        r2_ps <= area(r1_ps, 1'b0);
        r2_pl <= area(r1_pl, 1'b1);
    end

    // stage 3: moment and total
    logic [DiffWidth-1:0] w_pm, w_nm;
    logic                 r3_v, r3_neg;
    logic [DiffWidth-1:0] r3_diff;
    logic [TotWidth-1:0]  r3_tot;
    assign w_pm = (DiffWidth'(r2_pl) << 1) + DiffWidth'(r2_ps);
    assign w_nm = (DiffWidth'(r2_nl) << 1) + DiffWidth'(r2_ns);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_neg  <= w_nm > w_pm;
        r3_diff <= (w_nm > w_pm) ? w_nm - w_pm : w_pm - w_nm;
        r3_tot  <= TotWidth'(r2_nl) + TotWidth'(r2_ns) + TotWidth'(r2_z)
                 + TotWidth'(r2_ps) + TotWidth'(r2_pl);
    end

    // stage 4: scale by step
    logic                 r4_v, r4_neg;
    logic [ProdWidth-1:0] r4_mag;
    logic [TotWidth-1:0]  r4_tot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_neg <= r3_neg;
        r4_mag <= ProdWidth'(r3_diff) * ProdWidth'(i_step);
        r4_tot <= (r3_tot == '0) ? TotWidth'(1) : r3_tot;
    end

    // round to nearest: (2*mag + tot) / (2*tot), one quotient bit per stage
    logic [DivNumWidth:0]   r_dv_vld;
    logic [DivDenWidth:0]   r_dv_rem [DivNumWidth];
    logic [DivNumWidth-1:0] r_dv_quo [DivNumWidth+1];
    logic [DivNumWidth-1:0] r_dv_num [DivNumWidth];
    logic [DivDenWidth-1:0] r_dv_den [DivNumWidth];
    logic                   r_dv_neg [DivNumWidth+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_vld <= '0;
        else          r_dv_vld <= {r_dv_vld[DivNumWidth-1:0], r4_v};
    end

    always_ff @(posedge i_clk) begin
        r_dv_rem[0] <= '0;
        r_dv_quo[0] <= '0;
        r_dv_num[0] <= (DivNumWidth'(r4_mag) << 1) + DivNumWidth'(r4_tot);
        r_dv_den[0] <= {r4_tot, 1'b0};
        r_dv_neg[0] <= r4_neg;
    end

    for (genvar k = 0; k < DivNumWidth; k++) begin : g_div
        logic [DivDenWidth+1:0] w_trial;
        logic [DivDenWidth+1:0] w_sub;
        assign w_trial = {r_dv_rem[k], r_dv_num[k][DivNumWidth-1-k]};
        assign w_sub   = w_trial - {2'b00, r_dv_den[k]};
        always_ff @(posedge i_clk) begin
            r_dv_neg[k+1] <= r_dv_neg[k];
            r_dv_quo[k+1] <= {r_dv_quo[k][DivNumWidth-2:0], !w_sub[DivDenWidth+1]};
        end
        if (k < DivNumWidth - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_dv_num[k+1] <= r_dv_num[k];
                r_dv_den[k+1] <= r_dv_den[k];
                r_dv_rem[k+1] <= w_sub[DivDenWidth+1] ? w_trial[DivDenWidth:0]
                                                      : w_sub[DivDenWidth:0];
            end
        end
    end

    logic                   w_qv, w_qneg;
    logic [DivNumWidth-1:0] w_q;
    assign w_qv   = r_dv_vld[DivNumWidth];
    assign w_q    = r_dv_quo[DivNumWidth];
    assign w_qneg = r_dv_neg[DivNumWidth];

    logic [QuoWidth-1:0] w_rq;
    assign w_rq = (w_q > DivNumWidth'(32768)) ? QuoWidth'(32768) : w_q[QuoWidth-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= w_qv;
        if (w_qneg)                      o_result <= 16'(-w_rq);
        else if (w_rq > QuoWidth'(32767)) o_result <= 16'h7fff;
        else                             o_result <= w_rq[15:0];
    end

endmodule

// ===== design/fuzzy_pd_controller_center_of_sums_core.sv =====
// ----------------------------------------------------------------------------
// fuzzy_pd_controller_center_of_sums_core: fuzzy PD controller top level
// o_done rises after 30 fuzzify stages, 4 rule/area/moment/scale stages,
// 47 divide stages and 1 output register.
// Throughput: one word per cycle; busy is always low.
// The latency is set by the two bit-per-stage dividers in series.
// Synchronous active-low reset clears valid bits and restores register defaults.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller_center_of_sums_core
    import fpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_position,
    input  logic signed [15:0] i_velocity,
    output logic               o_done,
    output logic signed [15:0] o_angle_change,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [SpanWidth-1:0] r_pos_span, r_vel_span;
    logic [StepWidth-1:0] r_out_step;
    logic [1:0]           w_idx;
    logic                 w_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_span <= PosSpanReset;
            r_vel_span <= VelSpanReset;
            r_out_step <= OutStepReset;
        end else if (w_wr) begin
            unique case (w_idx)
                RegPosSpan: r_pos_span <= pwdata[SpanWidth-1:0];
                RegVelSpan: r_vel_span <= pwdata[SpanWidth-1:0];
                RegOutStep: r_out_step <= pwdata[StepWidth-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            RegPosSpan: prdata = 32'(r_pos_span);
            RegVelSpan: prdata = 32'(r_vel_span);
            RegOutStep: prdata = 32'(r_out_step);
            default:    prdata = '0;
        endcase
    end

    logic w_pv, w_vv;
    t_mu3 w_pmu, w_vmu;

    fpd_fuzz u_fz_pos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_x(i_position),
        .i_span(r_pos_span), .o_valid(w_pv), .o_mu(w_pmu)
    );

    fpd_fuzz u_fz_vel (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start), .i_x(i_velocity),
        .i_span(r_vel_span), .o_valid(w_vv), .o_mu(w_vmu)
    );

    logic [15:0] w_res;
    fpd_defuzz u_defuzz (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_pv && w_vv),
        .i_p(w_pmu), .i_v(w_vmu), .i_step(r_out_step),
        .o_valid(o_done), .o_result(w_res)
    );
    assign o_angle_change = w_res;

endmodule

// ===== design/fpd_checker.sv =====
// ----------------------------------------------------------------------------
// fpd_checker: port-level checks for the fuzzy PD controller
// Handshake, reset and result range properties, bound to the top level.
// ----------------------------------------------------------------------------
module fpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_angle_change,
    input logic        pready
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done after reset");
    // |result| is at most twice the 13-bit step, so the minimum code never shows
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_angle_change != 16'h8000)
        else $error("bad result");

endmodule

bind fuzzy_pd_controller_center_of_sums_core fpd_checker u_fpd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_done(o_done), .o_angle_change(o_angle_change), .pready(pready)
);

// ===== tb/fuzzy_pd_controller_center_of_sums_core_tb.sv =====
// ----------------------------------------------------------------------------
// fuzzy_pd_controller_center_of_sums_core_tb: self-checking bench for the core
// Drives position/velocity words with random gaps and rewrites the span and
// step registers over APB between phases. A scoreboard predicts the result of each
// driven word in order and compares it against every o_done word.
// ----------------------------------------------------------------------------
module fuzzy_pd_controller_center_of_sums_core_tb;
    import fpd_pkg::*;

    localparam int DrainCycles = 100;
    localparam int CycleLimit  = 400000;

    class angle_scoreboard;
        logic [SpanWidth-1:0] pos_span;
        logic [SpanWidth-1:0] vel_span;
        logic [StepWidth-1:0] step;
        logic signed [15:0]   pending[$];
        int                   mismatches;
        int                   failures;

        function void reset_regs();
            pos_span = PosSpanReset;
            vel_span = VelSpanReset;
            step     = OutStepReset;
        endfunction

        // q = floor(|x| * H / span) clamped to H
        function automatic longint unsigned member_q(logic signed [15:0] x,
                                                     logic [SpanWidth-1:0] span);
            longint unsigned mag;
            longint unsigned sp;
            longint unsigned q;
            mag = (x < 0) ? longint'(-longint'(x)) : longint'(x);
            sp  = (span == 0) ? 1 : span;
            q   = (mag << FracBits) / sp;
            return (q > (1 << FracBits)) ? (1 << FracBits) : q;
        endfunction

        function automatic longint unsigned lo(longint unsigned a, longint unsigned b);
            return (a < b) ? a : b;
        endfunction

        function automatic longint unsigned hi(longint unsigned a, longint unsigned b);
            return (a > b) ? a : b;
        endfunction

        function void note_input(logic signed [15:0] position, logic signed [15:0] velocity);
            longint unsigned full, qp, qv, l, c, r, gl, s, gr;
            longint unsigned nl, ns, z, ps, pl;
            longint unsigned a_nl, a_ns, a_z, a_ps, a_pl, total, pmag, nmag, mag, rnd;
            logic negative;
            longint res;
            full = 1 << FracBits;
            qp = member_q(position, pos_span);
            qv = member_q(velocity, vel_span);
            l  = (position < 0) ? qp : 0;
            r  = (position > 0) ? qp : 0;
            c  = full - qp;
            gl = (velocity < 0) ? qv : 0;
            gr = (velocity > 0) ? qv : 0;
            s  = full - qv;
            pl = lo(l, gl);
            ps = hi(lo(l, s), lo(c, gl));
            z  = hi(hi(lo(l, gr), lo(c, s)), lo(r, gl));
            ns = hi(lo(c, gr), lo(r, s));
            nl = lo(r, gr);
            a_nl = 4 * nl * full - nl * nl;
            a_pl = 4 * pl * full - pl * pl;
            a_ns = 4 * ns * full - 2 * ns * ns;
            a_z  = 4 * z * full - 2 * z * z;
            a_ps = 4 * ps * full - 2 * ps * ps;
            total = a_nl + a_ns + a_z + a_ps + a_pl;
            if (total == 0) total = 1;
            pmag = 2 * a_pl + a_ps;
            nmag = 2 * a_nl + a_ns;
            negative = nmag > pmag;
            mag = (negative ? nmag - pmag : pmag - nmag) * step;
            rnd = (2 * mag + total) / (2 * total);
            if (rnd > 32768) rnd = 32768;
            res = negative ? -longint'(rnd) : longint'(rnd);
            if (res > 32767) res = 32767;
            pending.push_back(16'(res));
        endfunction

        function void check_result(logic signed [15:0] angle);
            logic signed [15:0] want;
            if (pending.size() == 0) begin
                failures++;
                if (mismatches++ < 10)
                    $display("unexpected word: angle_change %0d", angle);
                return;
            end
            want = pending.pop_front();
            if (angle !== want) begin
                failures++;
                if (mismatches++ < 10)
                    $display("angle_change mismatch: expected %0d actual %0d", want, angle);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_position = '0;
    logic signed [15:0] i_velocity = '0;
    logic               o_done;
    logic signed [15:0] o_angle_change;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    angle_scoreboard sb = new();
    int cycles = 0;
    bit no_gaps;

    fuzzy_pd_controller_center_of_sums_core i_dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_done) sb.check_result(o_angle_change);

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = 4'(idx) << 2; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            RegPosSpan: sb.pos_span = value[SpanWidth-1:0];
            RegVelSpan: sb.vel_span = value[SpanWidth-1:0];
            RegOutStep: sb.step     = value[StepWidth-1:0];
            default: ;
        endcase
    endtask

    // Sender pause: everything in flight comes out before the next step
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // start is held high across back-to-back words; lowered only for a gap
    task automatic send_word(logic signed [15:0] position, logic signed [15:0] velocity);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start = 1'b1; i_position = position; i_velocity = velocity;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_input(position, velocity);
    endtask

    task automatic idle_start();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Mostly values near the spans so memberships land between 0 and 1
    function automatic logic signed [15:0] pick(logic [SpanWidth-1:0] span);
        int lim;
        if ($urandom_range(0, 3) == 0) return 16'($urandom());
        lim = 2 * int'(span) + 1;
        if (lim > 32767) lim = 32767;
        return 16'($urandom_range(0, 2 * lim) - lim);
    endfunction

    task automatic random_phase(int count);
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (count) send_word(pick(sb.pos_span), pick(sb.vel_span));
        idle_start();
        drain();
    endtask

    logic signed [15:0] corners[7];

    initial begin
        sb.reset_regs();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corner values against the reset spans
        corners = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd640, -16'sd1280};
        no_gaps = 1'b0;
        foreach (corners[k]) send_word(corners[k], corners[(k + 3) % 7]);
        for (int k = 0; k < 9; k++)
            send_word(16'((k / 3 - 1) * 640), 16'((k % 3 - 1) * 320));
        send_word(16'sd1280, 16'sd640);
        send_word(-16'sd1280, -16'sd640);
        idle_start();
        drain();
        random_phase(150);

        // extreme settings, zero spans and zero step among them
        write_reg(RegPosSpan, 32'd1); write_reg(RegVelSpan, 32'd1);
        write_reg(RegOutStep, 32'd8191);
        random_phase(150);
        write_reg(RegPosSpan, 32'd32767); write_reg(RegVelSpan, 32'd32767);
        write_reg(RegOutStep, 32'd0);
        random_phase(120);
        write_reg(RegPosSpan, 32'd0); write_reg(RegVelSpan, 32'd0);
        write_reg(RegOutStep, 32'hFFFF_FFFF);
        random_phase(120);
        write_reg(RegOutStep, 32'd8191);
        write_reg(RegPosSpan, 32'd32767); write_reg(RegVelSpan, 32'd1);
        random_phase(120);
        repeat (4) begin
            write_reg(RegPosSpan, 32'($urandom()));
            write_reg(RegVelSpan, 32'($urandom_range(1, 4000)));
            write_reg(RegOutStep, 32'($urandom_range(0, 8191)));
            random_phase(135);
        end

        if (sb.pending.size() != 0) sb.failures++;
        if (sb.failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/fpd_pkg.sv
design/fpd_div.sv
design/fpd_fuzz.sv
design/fpd_defuzz.sv
design/fuzzy_pd_controller_center_of_sums_core.sv
design/fpd_checker.sv
tb/fuzzy_pd_controller_center_of_sums_core_tb.sv
